FILE: rtl/msds_pkg.sv
package msds_pkg;

  // Scent is unsigned fixed point with one integer bit over the fraction bits; full scale is one.
  localparam int SCENT_FRAC_BITS = 16;
  localparam int SCENT_W         = SCENT_FRAC_BITS + 1;
  localparam logic [SCENT_W-1:0] SCENT_ONE = SCENT_W'(1) << SCENT_FRAC_BITS;

  // The sum of eight full-scale neighbors needs three more bits.
  localparam int SUM_W = SCENT_W + 3;

  // Field widths of the result item and of the configuration registers, and the minimum grid size.
  localparam int COL_W      = 8;
  localparam int ROW_W      = 12;
  localparam int GW_W       = 9;
  localparam int MIN_DIM    = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_X    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_Y    = 4'd3;

  // Input request: one grid cell in raster order.
  typedef struct packed {
    logic [SCENT_W-1:0] scent_prev;
    logic               walkable;
  } in_item_t;

  // Result request: new scent of one interior cell.
  typedef struct packed {
    logic [SCENT_W-1:0] new_scent;
    logic [COL_W-1:0]   cell_col;
    logic [ROW_W-1:0]   cell_row;
    logic               frame_last;
  } out_item_t;

  // One stored cell: walkable flag over the clamped scent.
  typedef struct packed {
    logic               walk;
    logic [SCENT_W-1:0] scent;
  } cell_t;

  // One line store entry holds the column's cells of the two rows above.
  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_pair_t;

endpackage

FILE: rtl/masked_scent_diffusion_stencil.sv
// A result passes stage one and then the output register once its window's last request is accepted.
// Throughput: one request per cycle unless a stalled result holds stage one; it is bounded by
// the single read and single write port of the line store.
// Each request reads its column entry when accepted and writes it back one stage later.
// Reset clears the counters, the window and the pipeline valids, and loads the configuration defaults.
// The line store is not cleared; no clearing pass runs and requests are taken right after reset.
module masked_scent_diffusion_stencil #(
  parameter int MAX_WIDTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  msds_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output msds_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [msds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msds_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WCNT_W = (ADDR_W + 1 > msds_pkg::GW_W) ? ADDR_W + 1 : msds_pkg::GW_W;
  localparam int XW     = (ADDR_W > msds_pkg::COL_W) ? ADDR_W : msds_pkg::COL_W;
  localparam int RW     = msds_pkg::ROW_W;

  // Configuration registers.
  logic [msds_pkg::GW_W-1:0]  grid_width_r;
  logic [RW-1:0]              grid_height_r;
  logic [msds_pkg::COL_W-1:0] source_x_r;
  logic [RW-1:0]              source_y_r;

  // Raster position of the next cell.
  logic [ADDR_W-1:0] col_r;
  logic [RW-1:0]     row_r;

  // Stage one: cell waiting for its line store data.
  logic                       s1_valid_r;
  logic [ADDR_W-1:0]          s1_addr_r;
  msds_pkg::cell_t            s1_cell_r;
  logic                       s1_emit_r;
  logic [msds_pkg::COL_W-1:0] s1_col_r;
  logic [RW-1:0]              s1_row_r;
  logic                       s1_last_r;

  // Line store and its registered read data.
  msds_pkg::line_pair_t line_mem [MAX_WIDTH];
  msds_pkg::line_pair_t rd_q_r;

  // Output register.
  logic                 out_valid_r;
  msds_pkg::out_item_t  out_data_r;

  // Combinational signals.
  logic                       accept;
  logic                       s1_adv;
  logic [WCNT_W-1:0]          gw_ext;
  logic [WCNT_W-1:0]          eff_w;
  logic [RW-1:0]              eff_h;
  logic [WCNT_W-1:0]          col_ext;
  logic [RW:0]                row_tmp;
  logic [ADDR_W-1:0]          col_cur;
  logic [RW-1:0]              row_cur;
  logic [WCNT_W-1:0]          col_inc;
  logic [RW:0]                row_inc;
  logic [ADDR_W-1:0]          col_nxt;
  logic [RW-1:0]              row_nxt;
  logic [msds_pkg::SCENT_W-1:0] scent_in;
  logic                       emit0;
  logic                       last0;
  logic [XW-1:0]              col_m1;
  logic [msds_pkg::SCENT_W-1:0] win_scent;

  // Handshakes.
  assign accept    = in_valid && !in_stall;
  assign s1_adv    = s1_valid_r && (!s1_emit_r || !out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Effective grid size after clamping.
  always_comb begin
    gw_ext = WCNT_W'(grid_width_r);
    if (gw_ext < WCNT_W'(msds_pkg::MIN_DIM)) begin
      eff_w = WCNT_W'(msds_pkg::MIN_DIM);
    end else if (gw_ext > WCNT_W'(MAX_WIDTH)) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = gw_ext;
    end
    eff_h = (grid_height_r < RW'(msds_pkg::MIN_DIM)) ? RW'(msds_pkg::MIN_DIM) : grid_height_r;
  end

  // Position of the arriving cell, its successor, and the center it completes.
  always_comb begin
    col_ext = WCNT_W'(col_r);
    row_tmp = {1'b0, row_r};
    col_cur = col_r;
    if (col_ext >= eff_w) begin
      col_cur = '0;
      row_tmp = row_tmp + (RW+1)'(1);
    end
    if (row_tmp >= {1'b0, eff_h}) begin
      row_tmp = '0;
    end
    row_cur = row_tmp[RW-1:0];

    col_inc = WCNT_W'(col_cur) + WCNT_W'(1);
    row_inc = {1'b0, row_cur} + (RW+1)'(1);
    col_nxt = col_inc[ADDR_W-1:0];
    row_nxt = row_cur;
    if (col_inc >= eff_w) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[RW-1:0];
    end

    emit0  = (WCNT_W'(col_cur) >= WCNT_W'(2)) && (row_cur >= RW'(2));
    last0  = (WCNT_W'(col_cur) == eff_w - WCNT_W'(1)) && (row_cur == eff_h - RW'(1));
    col_m1 = XW'(col_cur) - XW'(1);

    // Clamp the incoming scent and force the source cell to full scale.
    scent_in = (in_data.scent_prev > msds_pkg::SCENT_ONE) ? msds_pkg::SCENT_ONE
                                                          : in_data.scent_prev;
    if (XW'(col_cur) == XW'(source_x_r) && row_cur == source_y_r) begin
      scent_in = msds_pkg::SCENT_ONE;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= msds_pkg::GW_W'(80);
      grid_height_r <= RW'(50);
      source_x_r    <= '0;
      source_y_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msds_pkg::REG_GRID_WIDTH:  grid_width_r  <= cfg_data[msds_pkg::GW_W-1:0];
        msds_pkg::REG_GRID_HEIGHT: grid_height_r <= cfg_data[RW-1:0];
        msds_pkg::REG_SOURCE_X:    source_x_r    <= cfg_data[msds_pkg::COL_W-1:0];
        msds_pkg::REG_SOURCE_Y:    source_y_r    <= cfg_data[RW-1:0];
        default: ;
      endcase
    end
  end

  // Raster counters advance on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage one valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r       <= col_cur;
      s1_cell_r.walk  <= in_data.walkable;
      s1_cell_r.scent <= scent_in;
      s1_emit_r       <= emit0;
      s1_col_r        <= col_m1[msds_pkg::COL_W-1:0];
      s1_row_r        <= row_cur - RW'(1);
      s1_last_r       <= last0;
    end
  end

  // Line store: read the column at accept, write it back as the cell retires.
  // Back-to-back requests always address different columns, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= line_mem[col_cur];
    end
    if (s1_adv) begin
      line_mem[s1_addr_r] <= {rd_q_r.middle, s1_cell_r};
    end
  end

  msds_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift     (s1_adv),
    .up        (rd_q_r.upper),
    .mid       (rd_q_r.middle),
    .cur       (s1_cell_r),
    .new_scent (win_scent)
  );

  // Output register holds a result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emit_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit_r) begin
      out_data_r.new_scent  <= win_scent;
      out_data_r.cell_col   <= s1_col_r;
      out_data_r.cell_row   <= s1_row_r;
      out_data_r.frame_last <= s1_last_r;
    end
  end

endmodule

FILE: rtl/msds_window.sv
module msds_window (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             shift,
  input  msds_pkg::cell_t                  up,
  input  msds_pkg::cell_t                  mid,
  input  msds_pkg::cell_t                  cur,
  output logic [msds_pkg::SCENT_W-1:0]     new_scent
);

  // Two columns of three rows: entries 0..2 are two columns back, 3..5 one column back.
  msds_pkg::cell_t             win_r [6];
  logic [msds_pkg::SUM_W-1:0]  sum_a;
  logic [msds_pkg::SUM_W-1:0]  sum_b;
  logic [msds_pkg::SUM_W-1:0]  sum_all;
  logic [msds_pkg::SCENT_W-1:0] avg;

  // Shift in the new column whenever the cell under work retires.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= up;
      win_r[4] <= mid;
      win_r[5] <= cur;
    end
  end

  // Eight-neighbor sum as a two-level tree; the center is entry 4.
  always_comb begin
    sum_a = msds_pkg::SUM_W'(win_r[0].scent) + msds_pkg::SUM_W'(win_r[1].scent)
          + msds_pkg::SUM_W'(win_r[2].scent) + msds_pkg::SUM_W'(win_r[3].scent);
    sum_b = msds_pkg::SUM_W'(win_r[5].scent) + msds_pkg::SUM_W'(up.scent)
          + msds_pkg::SUM_W'(mid.scent) + msds_pkg::SUM_W'(cur.scent);
    sum_all = sum_a + sum_b;
    avg = sum_all[msds_pkg::SUM_W-1:3];
    if (avg > msds_pkg::SCENT_ONE) begin
      avg = msds_pkg::SCENT_ONE;
    end
    new_scent = win_r[4].walk ? avg : '0;
  end

endmodule

FILE: rtl/msds_checker.sv
module msds_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input msds_pkg::out_item_t out_data
);

  // A stalled result request stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  // A stalled result request keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // The averaged scent never exceeds full scale.
  a_scent_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.new_scent <= msds_pkg::SCENT_ONE)
    else $error("new scent above full scale");

  // Only interior cells are reported, never the top row or left column.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.cell_col != '0) && (out_data.cell_row != '0))
    else $error("border cell reported");

endmodule

bind masked_scent_diffusion_stencil msds_checker u_msds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
